// ===== hdl/bmprle_pkg.sv =====
// Shared constants, codes and types of the bitmap RLE run decoder.
package bmprle_pkg;

    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int PAL_ADDR_W = 8;
    localparam int PAL_DEPTH  = 256;
    localparam int KIND_W     = 2;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_COLOR   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESCAPE  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DX      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DY      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LITERAL = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PAD     = 3'd6;

    // escape codes following a zero count byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLIP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RLE4_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic               hit;
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column_start;
        logic [BYTE_W-1:0]  pixel_count;
    } run_t;

endpackage

// ===== hdl/bmprle_palette.sv =====
// Palette memory: one write port, two registered read ports.
module bmprle_palette
    import bmprle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [PAL_ADDR_W-1:0] wr_addr,
    input  logic [COLOR_W-1:0]    wr_data,
    input  logic                  rd_en,
    input  logic [PAL_ADDR_W-1:0] rd_addr_even,
    input  logic [PAL_ADDR_W-1:0] rd_addr_odd,
    output logic [COLOR_W-1:0]    rd_data_even,
    output logic [COLOR_W-1:0]    rd_data_odd
);

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] even_reg;
    logic [COLOR_W-1:0] odd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            even_reg <= mem[rd_addr_even];
            odd_reg  <= mem[rd_addr_odd];
        end
    end

    assign rd_data_even = even_reg;
    assign rd_data_odd  = odd_reg;

endmodule

// ===== hdl/bmprle_parser.sv =====
// Byte parser: phase tracking, position update, clipping and run descriptor.
module bmprle_parser
    import bmprle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  data_en,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  rle4_mode,
    input  logic [DIM_W-1:0]      image_width,
    input  logic [DIM_W-1:0]      image_height,
    output run_t                  run,
    output logic [PAL_ADDR_W-1:0] pal_addr_even,
    output logic [PAL_ADDR_W-1:0] pal_addr_odd,
    output logic                  finished
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DIM_W-1:0]   column_reg, column_next;
    logic [DIM_W-1:0]   file_row_reg, file_row_next;
    logic [BYTE_W-1:0]  run_length_reg, run_length_next;
    logic [BYTE_W-1:0]  literal_left_reg, literal_left_next;
    logic               pad_pending_reg, pad_pending_next;
    logic [BYTE_W-1:0]  delta_dx_reg, delta_dx_next;
    logic               finished_reg, finished_next;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W-1:0]   avail;
    logic [BYTE_W-1:0]  req;
    logic [BYTE_W-1:0]  lit_n;
    logic [DIM_W:0]     col_sum;
    logic [DIM_W-1:0]   col_adv;
    logic [DIM_W:0]     row_sum;
    logic [DIM_W-1:0]   row_flip;
    logic               clipped;
    logic [BYTE_W-1:0]  cnt;

    always_comb begin
        if (image_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (image_width > MAX_DIM) begin
            w_eff = MAX_DIM;
        end else begin
            w_eff = image_width;
        end
        if (image_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (image_height > MAX_DIM) begin
            h_eff = MAX_DIM;
        end else begin
            h_eff = image_height;
        end
    end

    // pixels one literal byte covers
    always_comb begin
        if (!rle4_mode) begin
            lit_n = BYTE_W'(1);
        end else if (literal_left_reg >= BYTE_W'(2)) begin
            lit_n = BYTE_W'(2);
        end else if (literal_left_reg == '0) begin
            lit_n = BYTE_W'(1);
        end else begin
            lit_n = literal_left_reg;
        end
    end

    always_comb begin
        case (phase_reg)
            PH_COLOR: req = run_length_reg;
            PH_DY:    req = delta_dx_reg;
            default:  req = lit_n;
        endcase
        avail    = (column_reg < w_eff) ? (w_eff - column_reg) : '0;
        clipped  = {{(DIM_W-BYTE_W){1'b0}}, req} > avail;
        cnt      = clipped ? avail[BYTE_W-1:0] : req;
        col_sum  = {1'b0, column_reg} + {{(DIM_W+1-BYTE_W){1'b0}}, req};
        col_adv  = (col_sum < {1'b0, w_eff}) ? col_sum[DIM_W-1:0] : w_eff;
        row_flip = (file_row_reg < h_eff) ? (h_eff - DIM_W'(1) - file_row_reg) : '0;
        row_sum  = {1'b0, file_row_reg} + ((phase_reg == PH_DY) ?
                   {{(DIM_W+1-BYTE_W){1'b0}}, data_byte} : (DIM_W+1)'(1));
    end

    always_comb begin
        if (rle4_mode) begin
            pal_addr_even = {4'h0, data_byte[7:4]};
            pal_addr_odd  = {4'h0, data_byte[3:0]};
        end else begin
            pal_addr_even = data_byte;
            pal_addr_odd  = data_byte;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        column_next       = column_reg;
        file_row_next     = file_row_reg;
        run_length_next   = run_length_reg;
        literal_left_next = literal_left_reg;
        pad_pending_next  = pad_pending_reg;
        delta_dx_next     = delta_dx_reg;
        finished_next     = finished_reg;
        run               = '0;
        if (data_en && !finished_reg) begin
            case (phase_reg)
                PH_COUNT: begin
                    if (data_byte != '0) begin
                        run_length_next = data_byte;
                        phase_next      = PH_COLOR;
                    end else begin
                        phase_next = PH_ESCAPE;
                    end
                end
                PH_COLOR: begin
                    phase_next       = PH_COUNT;
                    column_next      = col_adv;
                    run.hit          = 1'b1;
                    run.kind         = clipped ? KIND_CLIP : KIND_RUN;
                    run.row          = row_flip[COORD_W-1:0];
                    run.column_start = column_reg[COORD_W-1:0];
                    run.pixel_count  = cnt;
                end
                PH_ESCAPE: begin
                    phase_next = PH_COUNT;
                    case (data_byte)
                        ESC_EOL: begin
                            column_next = '0;
                            if (row_sum >= {1'b0, h_eff}) begin
                                file_row_next = h_eff;
                                finished_next = 1'b1;
                                run.hit       = 1'b1;
                                run.kind      = KIND_END;
                            end else begin
                                file_row_next = row_sum[DIM_W-1:0];
                            end
                        end
                        ESC_EOB: begin
                            finished_next = 1'b1;
                            run.hit       = 1'b1;
                            run.kind      = KIND_END;
                        end
                        ESC_DELTA: begin
                            phase_next = PH_DX;
                        end
                        default: begin
                            literal_left_next = data_byte;
                            pad_pending_next  = rle4_mode ? (data_byte[1] ^ data_byte[0])
                                                          : data_byte[0];
                            phase_next        = PH_LITERAL;
                        end
                    endcase
                end
                PH_DX: begin
                    delta_dx_next = data_byte;
                    phase_next    = PH_DY;
                end
                PH_DY: begin
                    phase_next  = PH_COUNT;
                    column_next = col_adv;
                    if (row_sum >= {1'b0, h_eff}) begin
                        file_row_next = h_eff;
                        finished_next = 1'b1;
                        run.hit       = 1'b1;
                        run.kind      = KIND_END;
                    end else begin
                        file_row_next = row_sum[DIM_W-1:0];
                    end
                end
                PH_LITERAL: begin
                    column_next       = col_adv;
                    run.hit           = 1'b1;
                    run.kind          = clipped ? KIND_CLIP : KIND_RUN;
                    run.row           = row_flip[COORD_W-1:0];
                    run.column_start  = column_reg[COORD_W-1:0];
                    run.pixel_count   = cnt;
                    literal_left_next = (literal_left_reg > lit_n) ?
                                        (literal_left_reg - lit_n) : '0;
                    if (literal_left_reg <= lit_n) begin
                        phase_next       = pad_pending_reg ? PH_PAD : PH_COUNT;
                        pad_pending_next = 1'b0;
                    end
                end
                default: begin
                    // pad byte, or an unused code: drop it
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_COUNT;
            column_reg       <= '0;
            file_row_reg     <= '0;
            run_length_reg   <= '0;
            literal_left_reg <= '0;
            pad_pending_reg  <= 1'b0;
            delta_dx_reg     <= '0;
            finished_reg     <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            column_reg       <= column_next;
            file_row_reg     <= file_row_next;
            run_length_reg   <= run_length_next;
            literal_left_reg <= literal_left_next;
            pad_pending_reg  <= pad_pending_next;
            delta_dx_reg     <= delta_dx_next;
            finished_reg     <= finished_next;
        end
    end

    assign finished = finished_reg;

endmodule

// ===== hdl/bmp_rle_run_decoder_core.sv =====
// Top level of the bitmap RLE8/RLE4 run decoder.
//
// Input stream (s_*): one request per cycle unless stalled. s_tuser selects palette
// write (1) or compressed data byte (0). Palette entries must be loaded before data
// that uses them (not enforced). Each data byte yields at most one run descriptor
// on m_*. Output stream (m_*): run descriptors with a top-down row, start column,
// clipped pixel count and an even/odd color pair; m_tuser carries the kind
// (pixel run, end of bitmap, run clipped at the row end).
// Configuration: cfg_wr_en writes cfg_wdata into the register selected by
// cfg_index (0 RLE4 mode, 1 width, 2 height); write only while idle.
// Pipeline: an accepted byte's result is registered in the parse register while
// the palette memory read completes, then moves to the output register.
// Throughput: one request per cycle unless stalled; the palette read is pipelined
// and never holds the input.
// Stall: with m_tready low the output register holds and the parse register
// fills; s_tready then drops until the output is taken.
// Reset: clears the parser to expect a count byte at the bottom file row,
// sets width and height to 1 and RLE8 mode; palette contents are kept.
module bmp_rle_run_decoder_core
    import bmprle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // data_byte, palette_index, palette_color
    input  logic [0:0]            s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // row, column_start, pixel_count,
                                             // color_even, color_odd
    output logic [KIND_W-1:0]     m_tuser,   // kind
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_wdata
);

    logic               rle4_mode_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    logic               s_accept;
    logic               data_en;
    logic               pal_wr_en;
    logic               advance;

    run_t               run;
    logic [PAL_ADDR_W-1:0] pal_addr_even;
    logic [PAL_ADDR_W-1:0] pal_addr_odd;
    logic [COLOR_W-1:0] pal_even;
    logic [COLOR_W-1:0] pal_odd;
    logic               finished;

    logic               p1_valid_reg, p1_valid_next;
    run_t               p1_run_reg;
    logic               m_valid_reg, m_valid_next;
    logic [79:0]        m_data_reg;
    logic [KIND_W-1:0]  m_kind_reg;
    logic [COLOR_W-1:0] col_even;
    logic [COLOR_W-1:0] col_odd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle4_mode_reg    <= 1'b0;
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RLE4_MODE:    rle4_mode_reg    <= cfg_wdata[0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign data_en   = s_accept && !s_tuser[0];
    assign pal_wr_en = s_accept && s_tuser[0];

    bmprle_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .data_en       (data_en),
        .data_byte     (s_tdata[7:0]),
        .rle4_mode     (rle4_mode_reg),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .run           (run),
        .pal_addr_even (pal_addr_even),
        .pal_addr_odd  (pal_addr_odd),
        .finished      (finished)
    );

    bmprle_palette u_palette (
        .aclk         (aclk),
        .wr_en        (pal_wr_en),
        .wr_addr      (s_tdata[15:8]),
        .wr_data      (s_tdata[39:16]),
        .rd_en        (data_en),
        .rd_addr_even (pal_addr_even),
        .rd_addr_odd  (pal_addr_odd),
        .rd_data_even (pal_even),
        .rd_data_odd  (pal_odd)
    );

    always_comb begin
        if (data_en && run.hit) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        m_valid_next = advance ? p1_valid_reg : m_valid_reg;
        // end of bitmap carries zero colors
        col_even = (p1_run_reg.kind == KIND_END) ? '0 : pal_even;
        col_odd  = (p1_run_reg.kind == KIND_END) ? '0 : pal_odd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_en && run.hit) begin
            p1_run_reg <= run;
        end
        if (advance && p1_valid_reg) begin
            m_kind_reg <= p1_run_reg.kind;
            m_data_reg <= {col_odd, col_even, p1_run_reg.pixel_count,
                           p1_run_reg.column_start, p1_run_reg.row};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    a_end_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END |-> m_tdata == '0)
        else $error("end-of-bitmap request carries nonzero payload");

    a_end_sets_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && p1_run_reg.kind == KIND_END |-> finished)
        else $error("end-of-bitmap queued but parser not finished");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> p1_valid_reg && m_valid_reg)
        else $error("input stalled with a free stage");

    a_no_run_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        finished && data_en |=> !p1_valid_reg || $stable(p1_run_reg))
        else $error("result produced after end of bitmap");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bitmap RLE8/RLE4 run decoder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmprle_pkg::*;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [BYTE_W-1:0] SHORTEST_LITERAL = 8'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column_start;
        logic [BYTE_W-1:0]  pixel_count;
        logic [COLOR_W-1:0] color_even;
        logic [COLOR_W-1:0] color_odd;
    } run_desc_t;

    typedef enum logic [1:0] {STIM_DATA, STIM_PALETTE, STIM_CONFIG} stim_kind_e;
    typedef enum logic [1:0] {END_ESCAPE, END_PAST_LAST_ROW, END_DELTA_OUT} end_way_e;

    // key: data byte, palette index or register index; value: color or register value
    typedef struct packed {
        stim_kind_e         what;
        logic [DIM_W-1:0]   key;
        logic [COLOR_W-1:0] value;
        logic               typed;
        run_desc_t          want;
    } stim_row_t;

    localparam run_desc_t NO_RUN = '0;

    localparam stim_row_t DIRECTED [31] = '{
        '{STIM_CONFIG,  13'(REG_IMAGE_WIDTH),  24'd0,       1'b0, NO_RUN},
        '{STIM_CONFIG,  13'(REG_IMAGE_HEIGHT), 24'd0,       1'b0, NO_RUN},
        '{STIM_PALETTE, 13'd0,                 24'h000000,  1'b0, NO_RUN},
        '{STIM_PALETTE, 13'd255,               24'hFFFFFF,  1'b0, NO_RUN},
        // a five pixel run into a one pixel row keeps one pixel
        '{STIM_DATA,    13'h05,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'hFF,                24'd0,       1'b1,
          '{KIND_CLIP, 12'd0, 12'd0, 8'd1, 24'hFFFFFF, 24'hFFFFFF}},
        // a run starting at the row end keeps nothing
        '{STIM_DATA,    13'h01,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h00,                24'd0,       1'b1,
          '{KIND_CLIP, 12'd0, 12'd1, 8'd0, 24'h000000, 24'h000000}},
        '{STIM_CONFIG,  13'(REG_IMAGE_WIDTH),  24'd8191,    1'b0, NO_RUN},
        '{STIM_CONFIG,  13'(REG_IMAGE_HEIGHT), 24'd4096,    1'b0, NO_RUN},
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'(ESC_EOL),          24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'hFF,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'hFF,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'(ESC_DELTA),        24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'hFF,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'hFF,                24'd0,       1'b0, NO_RUN},
        // odd literal block in 8-bit mode, then its pad byte
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h03,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h80,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h81,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h82,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN},
        '{STIM_CONFIG,  13'(REG_RLE4_MODE),    24'd1,       1'b0, NO_RUN},
        // five nibbles: two full bytes, a half byte, then a pad byte
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h05,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h12,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h34,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h5F,                24'd0,       1'b0, NO_RUN},
        '{STIM_DATA,    13'h00,                24'd0,       1'b0, NO_RUN}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata = '0;   // data_byte, palette_index, palette_color
    logic [0:0]           s_tuser = '0;   // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;        // row, column_start, pixel_count,
                                          // color_even, color_odd
    logic [KIND_W-1:0]    m_tuser;        // kind
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    bmp_rle_run_decoder_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // decoder shadow: configuration, parser state and palette
    logic               rle4 = 1'b0;
    logic [DIM_W-1:0]   width_reg = 13'd1;
    logic [DIM_W-1:0]   height_reg = 13'd1;
    logic [PHASE_W-1:0] ph = PH_COUNT;
    int                 col_pos = 0;
    int                 frow = 0;
    int                 run_len = 0;
    int                 lit_left = 0;
    logic               pad_due = 1'b0;
    int                 dx = 0;
    logic               done = 1'b0;
    logic [COLOR_W-1:0] pal_shadow [PAL_DEPTH];

    run_desc_t pending_runs [$];
    run_desc_t oldest_run;
    int        mismatches = 0;
    int        items_sent = 0;
    int        rx_hold = 0;
    bit        calm = 1'b0;
    bit        finishing = 1'b0;

    function automatic int dim_of(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return int'(MAX_DIM);
        return int'(v);
    endfunction

    task automatic paint(input int req, input logic [COLOR_W-1:0] ce, co,
                         output run_desc_t r);
        int w, h, avail, cnt, row;
        w = dim_of(width_reg);
        h = dim_of(height_reg);
        avail = (col_pos < w) ? w - col_pos : 0;
        cnt = (req < avail) ? req : avail;
        row = (frow < h) ? h - 1 - frow : 0;
        r.kind = (cnt < req) ? KIND_CLIP : KIND_RUN;
        r.row = row[COORD_W-1:0];
        r.column_start = col_pos[COORD_W-1:0];
        r.pixel_count = cnt[BYTE_W-1:0];
        r.color_even = ce;
        r.color_odd = co;
        col_pos = (col_pos + req < w) ? col_pos + req : w;
    endtask

    task automatic leave_check(output bit hit, output run_desc_t r);
        int h;
        h = dim_of(height_reg);
        hit = 1'b0;
        r = NO_RUN;
        if (frow >= h) begin
            frow = h;
            done = 1'b1;
            hit = 1'b1;
            r.kind = KIND_END;
        end
    endtask

    task automatic advance_decoder(input logic op, input logic [BYTE_W-1:0] b, idx,
                                   input logic [COLOR_W-1:0] color,
                                   output bit hit, output run_desc_t r);
        int n;
        int w;
        hit = 1'b0;
        r = NO_RUN;
        if (op == OP_PALETTE) begin
            pal_shadow[idx] = color;
            return;
        end
        if (done)
            return;
        case (ph)
            PH_COUNT: begin
                if (b != 0) begin
                    run_len = b;
                    ph = PH_COLOR;
                end else begin
                    ph = PH_ESCAPE;
                end
            end
            PH_COLOR: begin
                ph = PH_COUNT;
                hit = 1'b1;
                if (rle4)
                    paint(run_len, pal_shadow[b[7:4]], pal_shadow[b[3:0]], r);
                else
                    paint(run_len, pal_shadow[b], pal_shadow[b], r);
            end
            PH_ESCAPE: begin
                ph = PH_COUNT;
                if (b == ESC_EOL) begin
                    frow++;
                    col_pos = 0;
                    leave_check(hit, r);
                end else if (b == ESC_EOB) begin
                    done = 1'b1;
                    hit = 1'b1;
                    r.kind = KIND_END;
                end else if (b == ESC_DELTA) begin
                    ph = PH_DX;
                end else begin
                    lit_left = b;
                    // literal blocks are padded to whole 16-bit words
                    pad_due = rle4 ? (b[1:0] == 2'd1 || b[1:0] == 2'd2) : b[0];
                    ph = PH_LITERAL;
                end
            end
            PH_DX: begin
                dx = b;
                ph = PH_DY;
            end
            PH_DY: begin
                w = dim_of(width_reg);
                ph = PH_COUNT;
                col_pos = (col_pos + dx < w) ? col_pos + dx : w;
                frow += b;
                leave_check(hit, r);
            end
            PH_LITERAL: begin
                n = (rle4 && lit_left >= 2) ? 2 : 1;
                hit = 1'b1;
                if (rle4)
                    paint(n, pal_shadow[b[7:4]], pal_shadow[b[3:0]], r);
                else
                    paint(n, pal_shadow[b], pal_shadow[b], r);
                lit_left = (lit_left > n) ? lit_left - n : 0;
                if (lit_left == 0) begin
                    ph = pad_due ? PH_PAD : PH_COUNT;
                    pad_due = 1'b0;
                end
            end
            default: ph = PH_COUNT;
        endcase
    endtask

    task automatic push_item(input logic op, input logic [BYTE_W-1:0] b, idx,
                             input logic [COLOR_W-1:0] color, input logic typed,
                             input run_desc_t want);
        bit        hit;
        run_desc_t r;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {color, idx, b};
        do @(posedge aclk); while (!s_tready);
        advance_decoder(op, b, idx, color, hit, r);
        if (hit)
            pending_runs.push_back(typed ? want : r);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Keep the bitmap open: no end escape, no move past the last row.
    function automatic logic [BYTE_W-1:0] tame(logic [BYTE_W-1:0] b);
        int h;
        h = dim_of(height_reg);
        if (finishing)
            return b;
        if (ph == PH_ESCAPE && b == ESC_EOB)
            return SHORTEST_LITERAL;
        if (ph == PH_ESCAPE && b == ESC_EOL && frow + 1 >= h)
            return ESC_DELTA;
        if (ph == PH_DY && frow + b >= h)
            return 8'd0;
        return b;
    endfunction

    task automatic send_data(input logic [BYTE_W-1:0] b);
        push_item(OP_DATA, tame(b), 8'($urandom), 24'($urandom), 1'b0, NO_RUN);
    endtask

    task automatic send_palette();
        push_item(OP_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom), 1'b0, NO_RUN);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RLE4_MODE:    rle4 = value[0];
            REG_IMAGE_WIDTH:  width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
    endtask

    task automatic gen_sequence();
        int pick, n, nbytes;
        // resync: feed random bytes until the parser wants a count byte
        if (ph != PH_COUNT) begin
            send_data(8'($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_palette();
        end else if (pick < 18) begin
            send_data(8'($urandom));
        end else if (pick < 50) begin
            send_data(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(1, 16)));
            send_data(8'($urandom));
        end else if (pick < 62) begin
            send_data(8'd0);
            send_data(ESC_EOL);
        end else if (pick < 72) begin
            send_data(8'd0);
            send_data(ESC_DELTA);
            send_data(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)));
            send_data(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
        end else if (pick < 90) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
            nbytes = rle4 ? (n + 1) / 2 : n;
            send_data(8'd0);
            send_data(8'(n));
            repeat (nbytes) send_data(8'($urandom));
            if (rle4 ? (n % 4 == 1 || n % 4 == 2) : (n % 2 == 1))
                send_data(8'($urandom));
        end else begin
            // escape with an arbitrary code, possibly cut short later
            send_data(8'd0);
            send_data(8'($urandom));
        end
    endtask

    task automatic run_phase(input logic mode, input logic [DIM_W-1:0] w, h,
                             input int count);
        int first;
        write_reg(REG_RLE4_MODE, {12'd0, mode});
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        first = items_sent;
        while (items_sent - first < count) gen_sequence();
    endtask

    task automatic close_bitmap();
        int       h, step;
        end_way_e way;
        way = end_way_e'($urandom_range(0, 2));
        while (ph != PH_COUNT) send_data(8'($urandom));
        h = dim_of(height_reg);
        // climb to just below the top row with large deltas
        while (h - frow > 3) begin
            step = (h - frow - 3 > 255) ? 255 : h - frow - 3;
            send_data(8'd0);
            send_data(ESC_DELTA);
            send_data(8'($urandom));
            send_data(8'(step));
        end
        finishing = 1'b1;
        case (way)
            END_ESCAPE: begin
                send_data(8'd0);
                send_data(ESC_EOB);
            end
            END_PAST_LAST_ROW: begin
                while (!done) begin
                    send_data(8'd0);
                    send_data(ESC_EOL);
                end
            end
            default: begin
                send_data(8'd0);
                send_data(ESC_DELTA);
                send_data(8'($urandom));
                send_data(8'($urandom_range(h - frow, 255)));
            end
        endcase
        // everything after the end is dropped, palette writes still land
        repeat (20) begin
            if ($urandom_range(0, 3) == 0)
                send_palette();
            else
                send_data(8'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [COLOR_W-1:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_runs.size() == 0) begin
                $error("result with no run pending: kind %0d", m_tuser);
                mismatches++;
            end else begin
                oldest_run = pending_runs.pop_front();
                check_field("kind", oldest_run.kind, m_tuser);
                check_field("row", oldest_run.row, m_tdata[11:0]);
                check_field("column_start", oldest_run.column_start, m_tdata[23:12]);
                check_field("pixel_count", oldest_run.pixel_count, m_tdata[31:24]);
                check_field("color_even", oldest_run.color_even, m_tdata[55:32]);
                check_field("color_odd", oldest_run.color_odd, m_tdata[79:56]);
            end
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // load every palette entry so no read hits an unwritten one
        for (int i = 0; i < PAL_DEPTH; i++)
            push_item(OP_PALETTE, 8'($urandom), 8'(i), 24'($urandom), 1'b0, NO_RUN);
        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].what)
                STIM_CONFIG:
                    write_reg(DIRECTED[i].key[CFG_IDX_W-1:0], DIRECTED[i].value[DIM_W-1:0]);
                STIM_PALETTE:
                    push_item(OP_PALETTE, 8'($urandom), DIRECTED[i].key[7:0],
                              DIRECTED[i].value, 1'b0, NO_RUN);
                default:
                    push_item(OP_DATA, DIRECTED[i].key[7:0], 8'($urandom), 24'($urandom),
                              DIRECTED[i].typed, DIRECTED[i].want);
            endcase
        end
        run_phase(1'b1, 13'd0, 13'd4096, 10);
        run_phase(1'b0, 13'($urandom_range(1, 64)), 13'd4096, 10);
        run_phase(1'b1, 13'($urandom_range(1, 4096)), 13'd8191, 10);
        calm = 1'b1;
        run_phase(1'($urandom_range(0, 1)), 13'd4096, 13'd4096, 10);
        close_bitmap();
        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bmprle_pkg.sv
hdl/bmprle_palette.sv
hdl/bmprle_parser.sv
hdl/bmp_rle_run_decoder_core.sv
test/tb.sv
